### hw/rtl/socu_pkg.sv
package socu_pkg;

   // Configuration port geometry
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_CODE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_SLOT_BASE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAYER_SLOT_BASE = 2'd2;

   // Command codes
   localparam logic [7:0] CMD_NEXT_OFFSET = 8'h30;
   localparam logic [7:0] CMD_LOAD_BASE   = 8'h32;
   localparam logic [7:0] CMD_REGION      = 8'h99;
   localparam logic [7:0] CMD_SWAP_BASE   = 8'hba;
   localparam logic [7:0] CMD_TILE_ADDR   = 8'hc3;
   localparam logic [7:0] CMD_LAYER_ADDR  = 8'hcc;
   localparam logic [7:0] CMD_TEXT_ADDR   = 8'hd0;
   localparam logic [7:0] CMD_ROW_ADDR    = 8'hdc;
   localparam logic [7:0] CMD_SLOT_ADDR   = 8'he0;

   // Reply constants
   localparam logic [31:0] REPLY_DEFAULT    = 32'h0088_0000;
   localparam logic [31:0] TILE_ADDR_BASE   = 32'h0090_4000;
   localparam logic [31:0] TEXT_ADDR_BASE   = 32'h00a0_1000;
   localparam logic [31:0] ROW_ADDR_BASE    = 32'h00a0_0800;
   localparam logic [31:0] SLOT_ADDR_BASE   = 32'h00a0_0000;
   localparam logic [31:0] LAYER_ADDR_BASE  = 32'h0090_0000;

   // Offset windows that get moved by one page (offset bits 15..6)
   localparam logic [9:0]  PAGE_DOWN_WINDOW = 10'h19d;  // 0x6740..0x677f
   localparam logic [9:0]  PAGE_UP_WINDOW   = 10'h19e;  // 0x6780..0x67bf
   localparam logic [15:0] PAGE_STEP        = 16'h0100;

   // Descramble map selectors
   localparam logic [3:0] MAP_NONE = 4'd0;
   localparam logic [3:0] MAP_1    = 4'd1;
   localparam logic [3:0] MAP_2    = 4'd2;
   localparam logic [3:0] MAP_3    = 4'd3;
   localparam logic [3:0] MAP_4    = 4'd4;
   localparam logic [3:0] MAP_5    = 4'd5;
   localparam logic [3:0] MAP_6    = 4'd6;
   localparam logic [3:0] MAP_7    = 4'd7;
   localparam logic [3:0] MAP_8    = 4'd8;
   localparam logic [3:0] MAP_9    = 4'd9;
   localparam logic [3:0] MAP_10   = 4'd10;

   typedef logic [3:0] map_sel_type;

   function automatic map_sel_type bank_map(input logic [9:0] bank);
      map_sel_type m;
      case (bank)
         10'd0:   m = MAP_1;
         10'd1:   m = MAP_2;
         10'd2:   m = MAP_3;
         10'd3:   m = MAP_4;
         10'd4:   m = MAP_1;
         10'd5:   m = MAP_5;
         10'd6:   m = MAP_6;
         10'd7:   m = MAP_7;
         10'd8:   m = MAP_8;
         10'd9:   m = MAP_9;
         10'd10:  m = MAP_8;
         10'd11:  m = MAP_3;
         10'd12:  m = MAP_2;
         10'd13:  m = MAP_1;
         10'd14:  m = MAP_4;
         10'd15:  m = MAP_7;
         10'd16:  m = MAP_8;
         10'd17:  m = MAP_2;
         10'd18:  m = MAP_6;
         10'd19:  m = MAP_5;
         10'd20:  m = MAP_6;
         10'd21:  m = MAP_1;
         10'd22:  m = MAP_2;
         10'd23:  m = MAP_7;
         10'd24:  m = MAP_3;
         10'd25:  m = MAP_10;
         default: m = MAP_NONE;
      endcase
      return m;
   endfunction

   function automatic logic [15:0] scramble(input map_sel_type map_sel,
                                            input logic [15:0] v);
      logic [15:0] x;
      logic [15:0] r;
      x = v;
      r = '0;
      case (map_sel)
         MAP_1: begin
            x = v ^ 16'h0030;
            r = x & 16'hfc30;
            r[0] = x[1]; r[1] = x[6]; r[2] = x[7]; r[3] = x[8];
            r[6] = x[9]; r[7] = x[3]; r[8] = x[2]; r[9] = x[0];
         end
         MAP_2: begin
            x = v ^ 16'h03c0;
            r = x & 16'hffc0;
            r[0] = x[4]; r[1] = x[3]; r[2] = x[5];
            r[3] = x[0]; r[4] = x[2]; r[5] = x[1];
         end
         MAP_3: begin
            r = x & 16'hfc40;
            r[0] = x[1]; r[1] = x[2]; r[2] = x[9]; r[3] = x[5]; r[4] = x[7];
            r[5] = x[8]; r[7] = x[4]; r[8] = x[3]; r[9] = x[0];
         end
         MAP_4: begin
            x = v ^ 16'h0001;
            r = x & 16'hfc01;
            r[1] = x[7]; r[2] = x[8]; r[3] = x[9]; r[4] = x[1]; r[5] = x[2];
            r[6] = x[3]; r[7] = x[4]; r[8] = x[5]; r[9] = x[6];
         end
         MAP_5: begin
            x = v ^ 16'h01c0;
            r = x & 16'hfdc0;
            r[0] = x[1]; r[1] = x[0]; r[2] = x[9]; r[3] = x[5];
            r[4] = x[3]; r[5] = x[4]; r[9] = x[2];
         end
         MAP_6: begin
            x = v ^ 16'h0141;
            r = x & 16'hfd41;
            r[1] = x[3]; r[2] = x[5]; r[3] = x[9]; r[4] = x[7];
            r[5] = x[1]; r[7] = x[2]; r[9] = x[4];
         end
         MAP_7: begin
            x = v ^ 16'h0090;
            r = x & 16'hfc90;
            r[0] = x[6]; r[1] = x[8]; r[2] = x[9]; r[3] = x[0];
            r[5] = x[1]; r[6] = x[2]; r[8] = x[3]; r[9] = x[5];
         end
         MAP_8: begin
            x = v ^ 16'h02a1;
            r = x & 16'hfea1;
            r[1] = x[3]; r[2] = x[4]; r[3] = x[2];
            r[4] = x[6]; r[6] = x[8]; r[8] = x[1];
         end
         MAP_9: begin
            r = x & 16'hfc00;
            r[9:0] = {x[3:0], x[9:4]};
         end
         MAP_10: begin
            r = x & 16'hfc00;
            r[0] = x[5]; r[1] = x[4]; r[2] = x[3]; r[3] = x[2]; r[4] = x[1];
            r[5] = x[0]; r[6] = x[9]; r[7] = x[8]; r[8] = x[7]; r[9] = x[6];
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   // Descrambled sprite offset for a base and the low nibble of a position
   function automatic logic [15:0] sprite_offset(input logic [15:0] base,
                                                 input logic [3:0]  pos_low);
      logic [15:0] off;
      logic [15:0] r;
      off = {base[11:0], pos_low};
      r   = scramble(bank_map(base[15:6]), off);
      if (off[15:6] == PAGE_DOWN_WINDOW) begin
         r = r - PAGE_STEP;
      end else if (off[15:6] == PAGE_UP_WINDOW) begin
         r = r + PAGE_STEP;
      end
      return r;
   endfunction

endpackage

### hw/rtl/socu_if.sv
interface socu_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  command;
   logic [15:0] argument;

   modport source (output valid, output command, output argument, input ready);
   modport sink   (input valid, input command, input argument, output ready);
endinterface

interface socu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] reply_word;

   modport source (output valid, output reply_word, input ready);
   modport sink   (input valid, input reply_word, output ready);
endinterface

### hw/rtl/sprite_offset_command_unit.sv
// Sprite offset command unit.
// A command beat (command byte, 16-bit argument) enters on req_chan and
// produces exactly one 32-bit reply beat on rsp_chan, in order.
// Each reply is registered, into the skid entry when the output is stalled.
// Throughput: one command per cycle while req_chan.ready is high. All work for
// a command is one combinational pass from request port to reply register.
// The reply side has an output register plus one skid entry, so a new command
// is still taken while one finished reply waits; req_chan.ready drops only
// when both entries are full, and is driven from a register.
// A stalled reply holds its value until rsp_chan.ready takes it.
// The csr_ port writes region_code, tile_slot_base and layer_slot_base; write
// it only while no reply is outstanding. Writes to an unused index are dropped.
// Synchronous active-high reset clears the sprite base, sprite position,
// previous base, all three registers and both reply entries.
module sprite_offset_command_unit (
   input  logic                             clock,
   input  logic                             reset,
   socu_req_if.sink                         req_chan,
   socu_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [socu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [socu_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   // Configuration registers
   logic [7:0]  region_code_ff;
   logic [15:0] tile_slot_base_ff;
   logic [15:0] layer_slot_base_ff;

   // Walker state
   logic [15:0] sprite_base_ff,     sprite_base_in;
   logic [15:0] sprite_position_ff, sprite_position_in;
   logic [15:0] previous_base_ff,   previous_base_in;

   // Reply register and skid entry
   logic        out_valid_ff,  out_valid_in;
   logic [31:0] out_data_ff,   out_data_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [31:0] skid_data_ff,  skid_data_in;

   logic        push;
   logic        pop;
   logic        out_load;
   logic [31:0] reply;
   logic [15:0] layer_y;
   logic [22:0] tile_sum;
   logic [22:0] layer_sum;

   assign req_chan.ready      = !skid_valid_ff;
   assign push                = req_chan.valid && !skid_valid_ff;
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.reply_word = out_data_ff;
   assign pop                 = out_valid_ff && rsp_chan.ready;
   assign out_load            = !out_valid_ff || pop;

   // Sign-fold bit 10 of the layer argument: with bit 10 set the value is
   // the low ten bits less 0x400, taken modulo 2^16.
   assign layer_y   = req_chan.argument[10] ? {6'h3f, req_chan.argument[9:0]}
                                            : req_chan.argument;
   assign tile_sum  = {7'd0, tile_slot_base_ff} + {1'b0, req_chan.argument, 6'd0};
   assign layer_sum = {7'd0, layer_slot_base_ff} + {1'b0, layer_y, 6'd0};

   // Reply and state update for the command at the request port
   always_comb begin
      reply              = socu_pkg::REPLY_DEFAULT;
      sprite_base_in     = sprite_base_ff;
      sprite_position_in = sprite_position_ff;
      previous_base_in   = previous_base_ff;
      case (req_chan.command)
         socu_pkg::CMD_NEXT_OFFSET: begin
            reply = {16'd0, socu_pkg::sprite_offset(sprite_base_ff,
                                                     sprite_position_ff[3:0])};
            sprite_position_in = sprite_position_ff + 16'd1;
         end
         socu_pkg::CMD_LOAD_BASE: begin
            reply = {16'd0, socu_pkg::sprite_offset(req_chan.argument, 4'd0)};
            sprite_base_in     = req_chan.argument;
            sprite_position_in = 16'd1;
         end
         socu_pkg::CMD_SWAP_BASE: begin
            reply            = {16'd0, previous_base_ff};
            previous_base_in = req_chan.argument;
         end
         socu_pkg::CMD_REGION: begin
            reply            = socu_pkg::REPLY_DEFAULT | {16'd0, region_code_ff, 8'd0};
            previous_base_in = req_chan.argument;
         end
         socu_pkg::CMD_TILE_ADDR: begin
            reply = socu_pkg::TILE_ADDR_BASE + {7'd0, tile_sum, 2'd0};
         end
         socu_pkg::CMD_LAYER_ADDR: begin
            reply = socu_pkg::LAYER_ADDR_BASE + {7'd0, layer_sum, 2'd0};
         end
         socu_pkg::CMD_TEXT_ADDR: begin
            reply = socu_pkg::TEXT_ADDR_BASE + {11'd0, req_chan.argument, 5'd0};
         end
         socu_pkg::CMD_ROW_ADDR: begin
            reply = socu_pkg::ROW_ADDR_BASE + {10'd0, req_chan.argument, 6'd0};
         end
         socu_pkg::CMD_SLOT_ADDR: begin
            reply = socu_pkg::SLOT_ADDR_BASE + {21'd0, req_chan.argument[4:0], 6'd0};
         end
         default: begin
            reply = socu_pkg::REPLY_DEFAULT;
         end
      endcase
   end

   // Reply buffering: the output register refills from the skid entry first,
   // so beats leave in the order they came in.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_load) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = reply;
         end else begin
            out_valid_in  = push;
            out_data_in   = reply;
         end
      end else if (push) begin
         // Output stalled: park the new reply in the skid entry
         skid_valid_in = 1'b1;
         skid_data_in  = reply;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff       <= 1'b0;
         skid_valid_ff      <= 1'b0;
         sprite_base_ff     <= '0;
         sprite_position_ff <= '0;
         previous_base_ff   <= '0;
         region_code_ff     <= '0;
         tile_slot_base_ff  <= '0;
         layer_slot_base_ff <= '0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (push) begin
            sprite_base_ff     <= sprite_base_in;
            sprite_position_ff <= sprite_position_in;
            previous_base_ff   <= previous_base_in;
         end
         if (csr_write_enable) begin
            case (csr_index)
               socu_pkg::CSR_REGION_CODE:     region_code_ff     <= csr_write_data[7:0];
               socu_pkg::CSR_TILE_SLOT_BASE:  tile_slot_base_ff  <= csr_write_data;
               socu_pkg::CSR_LAYER_SLOT_BASE: layer_slot_base_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // The skid entry only fills behind a held output beat
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid while output register empty");

   // A beat taken while the output stalls must land in the skid entry
   assert property (@(posedge clock) disable iff (reset)
      (push && out_valid_ff && !rsp_chan.ready) |=> skid_valid_ff)
      else $error("beat taken under stall was dropped");

   // Loading a base restarts the walk at position one
   assert property (@(posedge clock) disable iff (reset)
      (push && req_chan.command == socu_pkg::CMD_LOAD_BASE)
      |=> sprite_position_ff == 16'd1)
      else $error("position not restarted by base load");

   // Each next-offset command advances the position by one
   assert property (@(posedge clock) disable iff (reset)
      (push && req_chan.command == socu_pkg::CMD_NEXT_OFFSET)
      |=> sprite_position_ff == 16'($past(sprite_position_ff) + 16'd1))
      else $error("position not advanced by next-offset command");

endmodule
